// ===== hdl/dkon_pkg.sv =====
// Shared types and constants for the downward k-out-of-n failure check.
// No dependencies; imported by downward_k_out_of_n_check_core.
`default_nettype none
package dkon_pkg;

  localparam int RingDepth = 16;
  localparam int IdxW      = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int KCntW     = $clog2(RingDepth + 1);

  localparam int SnW       = 32;
  localparam int KThreshW  = 5;
  localparam int WindowW   = 31;
  localparam int CountW    = 5;
  localparam int CfgDataW  = 31;
  localparam int CfgIdxW   = 1;

  // item kinds
  localparam logic [1:0] KindRecord = 2'd0;
  localparam logic [1:0] KindCheck  = 2'd1;
  localparam logic [1:0] KindClear  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowN    = 1'd1;

  typedef struct packed {
    logic [1:0]     kind;
    logic [SnW-1:0] seq_num;
  } in_item_t;

  typedef struct packed {
    logic              threshold_met;
    logic [CountW-1:0] fresh_count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/downward_k_out_of_n_check_core.sv =====
// Downward k-out-of-n failure check: ring of failed SNs with a serial window scan.
// Depends on dkon_pkg (types, ring depth, kind and register codes).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) takes one item per transfer:
//   record stores an SN in the ring at the write index, clear drops every fresh
//   mark, check scans the ring against the current SN. Only a check produces a
//   result on the output channel (out_valid_o/out_ready_i, out_data_o).
//   Record, clear and the unused kind finish in the transfer cycle; the block is
//   ready again on the next cycle.
//   A check scans the first k ring entries, one per cycle, through the shared window
//   comparator (k = effective threshold, 1..16), then loads the output register.
//   The next item is taken the cycle after that load, so the input stays blocked
//   for the whole check.
//   The output register holds a finished result while the receiver stalls; a
//   further check scans meanwhile and then waits for the register to free up.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
//   and are expected only while the block is idle.
//   Reset clears all fresh marks and the write index, sets k to 1 and the
//   window to 16.
`default_nettype none
module downward_k_out_of_n_check_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire dkon_pkg::in_item_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output dkon_pkg::out_item_t               out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [dkon_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dkon_pkg::CfgDataW-1:0] cfg_data_i
);
  import dkon_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [KThreshW-1:0] k_thresh_q;
  logic [WindowW-1:0]  window_q;
  logic [SnW-1:0]      ring_sn_q [RingDepth];
  logic [RingDepth-1:0] fresh_q;
  logic [IdxW-1:0]     wr_idx_q;
  logic [IdxW-1:0]     scan_idx_q;
  logic [KCntW-1:0]    cnt_q;
  logic [SnW-1:0]      cur_q;
  logic [SnW-1:0]      low_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [KCntW-1:0]    eff_k;
  logic                in_fire;
  logic                out_free;
  logic [KCntW-1:0]    rec_pos;
  logic [KCntW-1:0]    rec_next;
  logic [SnW-1:0]      entry_sn;
  logic [SnW-1:0]      diff_low;
  logic [SnW-1:0]      diff_cur;
  logic                in_window;
  logic                scan_last;

  // k saturated to 1..RingDepth
  always_comb begin
    if (k_thresh_q == '0) begin
      eff_k = KCntW'(1);
    end else if (int'(k_thresh_q) > RingDepth) begin
      eff_k = KCntW'(RingDepth);
    end else begin
      eff_k = KCntW'(k_thresh_q);
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // record slot: a stale write index at or past k restarts at entry 0
  assign rec_pos  = (KCntW'(wr_idx_q) < eff_k) ? KCntW'(wr_idx_q) : '0;
  assign rec_next = ((rec_pos + KCntW'(1)) >= eff_k) ? '0 : (rec_pos + KCntW'(1));

  // shared window comparator: (cur - n, cur] in serial arithmetic
  assign entry_sn  = ring_sn_q[scan_idx_q];
  assign diff_low  = low_q - entry_sn;
  assign diff_cur  = entry_sn - cur_q;
  assign in_window = diff_low[SnW-1] && ((entry_sn == cur_q) || diff_cur[SnW-1]);
  assign scan_last = ((KCntW'(scan_idx_q) + KCntW'(1)) == eff_k);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_data_i.kind == KindCheck)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_thresh_q  <= KThreshW'(1);
      window_q    <= WindowW'(16);
      fresh_q     <= '0;
      wr_idx_q    <= '0;
      scan_idx_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgKThreshold: k_thresh_q <= cfg_data_i[KThreshW-1:0];
          CfgWindowN:    window_q   <= cfg_data_i[WindowW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        case (in_data_i.kind)
          KindRecord: begin
            fresh_q[rec_pos[IdxW-1:0]] <= 1'b1;
            wr_idx_q                   <= rec_next[IdxW-1:0];
          end
          KindCheck: begin
            scan_idx_q <= '0;
            cnt_q      <= '0;
          end
          KindClear: fresh_q <= '0;
          default: ;
        endcase
      end

      if (state_q == StScan) begin
        if (fresh_q[scan_idx_q]) begin
          if (in_window) begin
            cnt_q <= cnt_q + KCntW'(1);
          end else begin
            fresh_q[scan_idx_q] <= 1'b0;
          end
        end
        scan_idx_q <= scan_idx_q + IdxW'(1);
      end

      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_data_i.kind == KindRecord)) begin
      ring_sn_q[rec_pos[IdxW-1:0]] <= in_data_i.seq_num;
    end
    if (in_fire && (in_data_i.kind == KindCheck)) begin
      cur_q <= in_data_i.seq_num;
      low_q <= in_data_i.seq_num - SnW'(window_q);
    end
    if (state_q == StDone && out_free) begin
      out_q.threshold_met <= (cnt_q >= eff_k);
      out_q.fresh_count   <= CountW'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_check_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.kind == KindCheck) |=> state_q == StScan)
    else $error("check transfer did not start a scan");

  a_other_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.kind != KindCheck) |=> state_q == StIdle)
    else $error("record or clear left idle");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> KCntW'(cnt_q) <= KCntW'(scan_idx_q))
    else $error("fresh count ran ahead of scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised outside done state");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> KCntW'(scan_idx_q) < eff_k)
    else $error("scan index past k");

endmodule
`default_nettype wire

// ===== dv/downward_k_out_of_n_check_core_tb.sv =====
// Testbench for downward_k_out_of_n_check_core: directed and random record, check and clear
// items, each check's count and threshold flag compared against a ring predictor.
// Depends on dkon_pkg and the core RTL.
`default_nettype none
module downward_k_out_of_n_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dkon_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ItemsPerPhase = 144;

  // Ring predictor plus queue of expected check results.
  class fail_ring_scoreboard;
    logic [SnW-1:0]      ring_sn [RingDepth];
    bit                  ring_fresh [RingDepth];
    int unsigned         wr_idx;
    logic [KThreshW-1:0] k_reg;
    logic [WindowW-1:0]  win_reg;
    out_item_t           check_results_q [$];
    int unsigned         errors, compared, n_record, n_check, n_clear, n_unused;

    function new();
      for (int i = 0; i < RingDepth; i++) begin
        ring_sn[i] = '0;
        ring_fresh[i] = 1'b0;
      end
      wr_idx = 0;
      k_reg = KThreshW'(1);
      win_reg = WindowW'(16);
    endfunction

    function void write_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgKThreshold) k_reg = data[KThreshW-1:0];
      else if (idx == CfgWindowN) win_reg = data[WindowW-1:0];
    endfunction

    function void note_item(in_item_t it);
      int unsigned k, pos, cnt;
      logic [SnW-1:0] low, d_low, d_cur;
      out_item_t res;
      if (k_reg == 0) k = 1;
      else if (k_reg > RingDepth) k = RingDepth;
      else k = k_reg;
      case (it.kind)
        KindRecord: begin
          n_record++;
          pos = (wr_idx < k) ? wr_idx : 0;
          ring_sn[pos] = it.seq_num;
          ring_fresh[pos] = 1'b1;
          wr_idx = (pos + 1 >= k) ? 0 : pos + 1;
        end
        KindCheck: begin
          n_check++;
          low = it.seq_num - {1'b0, win_reg};
          cnt = 0;
          for (int i = 0; i < k; i++) begin
            if (ring_fresh[i]) begin
              // serial window (low, current]
              d_low = low - ring_sn[i];
              d_cur = ring_sn[i] - it.seq_num;
              if (d_low[SnW-1] && (ring_sn[i] == it.seq_num || d_cur[SnW-1])) begin
                cnt++;
              end else begin
                ring_fresh[i] = 1'b0;
                ring_sn[i] = '0;
              end
            end
          end
          res.threshold_met = (cnt >= k);
          res.fresh_count = CountW'(cnt);
          check_results_q.push_back(res);
        end
        KindClear: begin
          n_clear++;
          for (int i = 0; i < RingDepth; i++) begin
            ring_sn[i] = '0;
            ring_fresh[i] = 1'b0;
          end
        end
        default: n_unused++;
      endcase
    endfunction

    function void compare_result(out_item_t got);
      out_item_t exp_res;
      if (check_results_q.size() == 0) begin
        $error("unexpected result: threshold_met=%0d fresh_count=%0d",
               got.threshold_met, got.fresh_count);
        errors++;
        return;
      end
      exp_res = check_results_q.pop_front();
      compared++;
      if (got.threshold_met !== exp_res.threshold_met) begin
        $error("threshold_met: expected %0d, actual %0d", exp_res.threshold_met,
               got.threshold_met);
        errors++;
      end
      if (got.fresh_count !== exp_res.fresh_count) begin
        $error("fresh_count: expected %0d, actual %0d", exp_res.fresh_count,
               got.fresh_count);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  fail_ring_scoreboard sb = new();
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  downward_k_out_of_n_check_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_config(cfg_idx_i, cfg_data_i);
      if (out_valid_o && out_ready_i) sb.compare_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_item(in_data_i);
      if (cfg_we_i || (out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [SnW-1:0] sn);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= '{kind: kind, seq_num: sn};
    do @(posedge clk_i); while (!in_ready_o);
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.check_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [KThreshW-1:0] k, logic [WindowW-1:0] win);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgKThreshold;
    cfg_data_i <= CfgDataW'(k);
    @(posedge clk_i);
    cfg_idx_i <= CfgWindowN;
    cfg_data_i <= CfgDataW'(win);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [KThreshW-1:0] k_tab [8];
    logic [WindowW-1:0]  win_tab [8];
    logic [SnW-1:0]      base, sn;
    logic [1:0]          kind;
    int unsigned         span, r, n;

    k_tab = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd9, 5'd12};
    win_tab = '{31'd1, 31'h7FFF_FFFF, 31'd16, 31'd0, 31'd40, 31'd7, 31'd100, 31'd0};
    win_tab[7] = WindowW'($urandom_range(1, 32'h7FFF_FFFF));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings k=1, window 16
    send_item(KindCheck, 32'h0);
    send_item(KindRecord, 32'hFFFF_FFFF);
    send_item(KindCheck, 32'h0000_000E);   // wraps below zero, still inside
    send_item(KindCheck, 32'h0000_000F);   // now on the low edge: dropped
    send_item(KindRecord, 32'd5);
    send_item(KindUnused, 32'hFFFF_FFFF);
    send_item(KindClear, 32'd5);
    send_item(KindCheck, 32'd5);
    wait_idle();
    // zero k acts as one, empty window clears everything
    set_config(5'd0, 31'd0);
    send_item(KindRecord, 32'd7);
    send_item(KindCheck, 32'd7);
    wait_idle();
    // k saturates at ring depth, widest window
    set_config(5'd31, 31'h7FFF_FFFF);
    send_item(KindRecord, 32'h8000_0000);
    send_item(KindRecord, 32'h7FFF_FFFF);
    send_item(KindRecord, 32'h0);
    send_item(KindRecord, 32'hAAAA_AAAA);
    send_item(KindRecord, 32'h5555_5555);
    send_item(KindRecord, 32'h1);
    send_item(KindCheck, 32'h7FFF_FFFF);
    wait_idle();
    // lowered k with write index past it: record wraps to entry 0
    set_config(5'd3, 31'h7FFF_FFFF);
    send_item(KindRecord, 32'h10);
    send_item(KindCheck, 32'h10);
    wait_idle();
    // entries beyond the lowered k were left alone
    set_config(5'd16, 31'd100);
    send_item(KindCheck, 32'h7FFF_FFFF);
    send_item(KindCheck, 32'h0000_0040);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_config(k_tab[ph], win_tab[ph]);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 49; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 49; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      span = (win_tab[ph] > 64) ? 200 : 2 * win_tab[ph] + 2;
      base = $urandom;
      n = 0;
      while (n < ItemsPerPhase) begin
        r = $urandom_range(99);
        if (r < 48) begin
          kind = KindRecord;
          sn = (r < 6) ? $urandom : base - $urandom_range(0, span);
        end else if (r < 88) begin
          kind = KindCheck;
          base = base + $urandom_range(0, 3);
          sn = (r < 85) ? base : $urandom;
        end else if (r < 96) begin
          kind = KindClear;
          sn = $urandom;
        end else begin
          kind = KindUnused;
          sn = $urandom;
        end
        send_item(kind, sn);
        if (kind != KindUnused) n++;
      end
    end

    wait_idle();
    gap_pct = 0;
    repeat (20) @(posedge clk_i);
    $display("Ran %0d records, %0d checks, %0d clears, %0d unused-kind items",
             sb.n_record, sb.n_check, sb.n_clear, sb.n_unused);
    $display("over 13 k/window settings, %0d results compared, %0d errors",
             sb.compared, sb.errors);
    if (sb.errors == 0 && sb.check_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
